// ===== hw/rtl/etvm_pkg.sv =====
// Package: shared types and constants for the view matrix unit.
`timescale 1ns / 1ps
package etvm_pkg;
	localparam int CORDIC_STEPS = 30;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [33:0] QUARTER = 34'sd1073741824;
	localparam logic signed [33:0] HALF = 34'sd2147483648;

	typedef logic signed [33:0] cw_t;

	typedef struct packed {
		cw_t x;
		cw_t y;
		cw_t z;
		logic flip;
	} cs_t;

	typedef struct packed {
		cs_t p;
		cs_t w;
		cs_t r;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] pz;
	} lane_t;

	typedef struct packed {
		logic signed [15:0] m00;
		logic signed [15:0] m01;
		logic signed [15:0] m02;
		logic signed [15:0] m10;
		logic signed [15:0] m11;
		logic signed [15:0] m12;
		logic signed [15:0] m20;
		logic signed [15:0] m21;
		logic signed [15:0] m22;
		logic signed [31:0] trans_x;
		logic signed [31:0] trans_y;
		logic signed [31:0] trans_z;
	} res_t;

	function automatic cw_t atan_tab(input int i);
		case (i)
			0: atan_tab = 34'sd536870912;
			1: atan_tab = 34'sd316933406;
			2: atan_tab = 34'sd167458907;
			3: atan_tab = 34'sd85004756;
			4: atan_tab = 34'sd42667331;
			5: atan_tab = 34'sd21354465;
			6: atan_tab = 34'sd10679838;
			7: atan_tab = 34'sd5340245;
			8: atan_tab = 34'sd2670163;
			9: atan_tab = 34'sd1335087;
			10: atan_tab = 34'sd667544;
			11: atan_tab = 34'sd333772;
			12: atan_tab = 34'sd166886;
			13: atan_tab = 34'sd83443;
			14: atan_tab = 34'sd41722;
			15: atan_tab = 34'sd20861;
			16: atan_tab = 34'sd10430;
			17: atan_tab = 34'sd5215;
			18: atan_tab = 34'sd2608;
			19: atan_tab = 34'sd1304;
			20: atan_tab = 34'sd652;
			21: atan_tab = 34'sd326;
			22: atan_tab = 34'sd163;
			23: atan_tab = 34'sd81;
			24: atan_tab = 34'sd41;
			25: atan_tab = 34'sd20;
			26: atan_tab = 34'sd10;
			27: atan_tab = 34'sd5;
			28: atan_tab = 34'sd3;
			29: atan_tab = 34'sd1;
			default: atan_tab = '0;
		endcase
	endfunction

	function automatic cs_t cordic_step(input cs_t a, input int i);
		cs_t o;
		o = a;
		if (!a.z[33]) begin
			o.x = a.x - (a.y >>> i);
			o.y = a.y + (a.x >>> i);
			o.z = a.z - atan_tab(i);
		end else begin
			o.x = a.x + (a.y >>> i);
			o.y = a.y - (a.x >>> i);
			o.z = a.z + atan_tab(i);
		end
		return o;
	endfunction
endpackage

// ===== hw/rtl/etvm_if.sv =====
// Interface: valid/ready channel carrying one word of type T.
`timescale 1ns / 1ps
interface etvm_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/etvm_cell.sv =====
// CORDIC cell: one micro-rotation for all three angles of one word.
`timescale 1ns / 1ps
module etvm_cell #(
	parameter int STEP = 0
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic vin,
	input etvm_pkg::lane_t din,
	output logic vout,
	output etvm_pkg::lane_t dout
);
	import etvm_pkg::*;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vout <= 1'b0;
		else if (en) vout <= vin;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			dout.p <= cordic_step(din.p, STEP);
			dout.w <= cordic_step(din.w, STEP);
			dout.r <= cordic_step(din.r, STEP);
			dout.px <= din.px;
			dout.py <= din.py;
			dout.pz <= din.pz;
		end
	end
endmodule

// ===== hw/rtl/etvm_matrix.sv =====
// Matrix back end: rounding, products, translation and saturation.
`timescale 1ns / 1ps
module etvm_matrix #(
	parameter int ROT_FRAC_BITS = 14
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic vin,
	input etvm_pkg::lane_t din,
	output logic vout,
	output etvm_pkg::res_t dout
);
	import etvm_pkg::*;
	localparam int RF = ROT_FRAC_BITS;
	localparam int EW = RF + 3;
	localparam int PW = 2 * EW + 2;
	localparam int TW = EW + 36;
	typedef logic signed [EW-1:0] e_t;

	function automatic e_t clampu(input logic signed [63:0] v);
		logic signed [63:0] one;
		one = 64'sd1 <<< RF;
		if (v > one) return EW'(one);
		if (v < -one) return EW'(-one);
		return EW'(v);
	endfunction
	function automatic e_t unit(input cw_t v, input logic f);
		logic signed [63:0] t;
		t = 64'(v);
		if (f) t = -t;
		t = (t + (64'sd1 <<< (29 - RF))) >>> (30 - RF);
		return clampu(t);
	endfunction
	function automatic e_t fm(input e_t a, input e_t b);
		logic signed [PW-1:0] t;
		t = PW'(a) * PW'(b);
		t = (t + (PW'(1) <<< (RF - 1))) >>> RF;
		return EW'(t);
	endfunction

	logic v1_s1, v2_s2, v3_s3, v4_s4;
	e_t sx_s1, cx_s1, sy_s1, cy_s1, sz_s1, cz_s1;
	logic signed [32:0] nx_s1, ny_s1, nz_s1, nx_s2, ny_s2, nz_s2, nx_s3, ny_s3, nz_s3;
	e_t sx_s2, cx_s2, cc_s2, cs_s2, sc_s2, ss_s2, m02_s2, m10_s2, m11_s2, m22_s2;
	e_t m_s3 [9];
	logic signed [TW-1:0] pr_s4 [9];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0; v2_s2 <= 1'b0; v3_s3 <= 1'b0; v4_s4 <= 1'b0; vout <= 1'b0;
		end else if (en) begin
			v1_s1 <= vin; v2_s2 <= v1_s1; v3_s3 <= v2_s2; v4_s4 <= v3_s3; vout <= v4_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s1 <= unit(din.p.y, din.p.flip); cx_s1 <= unit(din.p.x, din.p.flip);
			sy_s1 <= unit(din.w.y, din.w.flip); cy_s1 <= unit(din.w.x, din.w.flip);
			sz_s1 <= unit(din.r.y, din.r.flip); cz_s1 <= unit(din.r.x, din.r.flip);
			nx_s1 <= -33'(din.px); ny_s1 <= -33'(din.py); nz_s1 <= -33'(din.pz);
			sx_s2 <= sx_s1; cx_s2 <= cx_s1;
			cc_s2 <= fm(cy_s1, cz_s1); cs_s2 <= fm(cy_s1, sz_s1);
			sc_s2 <= fm(sy_s1, cz_s1); ss_s2 <= fm(sy_s1, sz_s1);
			m02_s2 <= fm(cx_s1, sy_s1); m10_s2 <= fm(cx_s1, sz_s1);
			m11_s2 <= fm(cx_s1, cz_s1); m22_s2 <= fm(cy_s1, cx_s1);
			nx_s2 <= nx_s1; ny_s2 <= ny_s1; nz_s2 <= nz_s1;
			m_s3[0] <= clampu(64'(cc_s2) + 64'(fm(ss_s2, sx_s2)));
			m_s3[1] <= clampu(64'(fm(sc_s2, sx_s2)) - 64'(cs_s2));
			m_s3[2] <= clampu(64'(m02_s2));
			m_s3[3] <= clampu(64'(m10_s2));
			m_s3[4] <= clampu(64'(m11_s2));
			m_s3[5] <= clampu(-64'(sx_s2));
			m_s3[6] <= clampu(64'(fm(cs_s2, sx_s2)) - 64'(sc_s2));
			m_s3[7] <= clampu(64'(fm(cc_s2, sx_s2)) + 64'(ss_s2));
			m_s3[8] <= clampu(64'(m22_s2));
			nx_s3 <= nx_s2; ny_s3 <= ny_s2; nz_s3 <= nz_s2;
			for (int c = 0; c < 3; c++) begin
				pr_s4[c] <= TW'(m_s3[c]) * TW'(nx_s3);
				pr_s4[3 + c] <= TW'(m_s3[3 + c]) * TW'(ny_s3);
				pr_s4[6 + c] <= TW'(m_s3[6 + c]) * TW'(nz_s3);
			end
		end
	end

	logic signed [TW-1:0] ms_s4 [9];
	logic signed [TW+1:0] acc [3];
	logic signed [31:0] tr [3];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 9; i++) ms_s4[i] <= TW'(m_s3[i]);
		end
	end
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			acc[c] = (TW+2)'(pr_s4[c]) + (TW+2)'(pr_s4[3 + c]) + (TW+2)'(pr_s4[6 + c]);
			acc[c] = (acc[c] + ((TW+2)'(1) <<< (RF - 1))) >>> RF;
			if (acc[c] > (TW+2)'(64'sd2147483647)) tr[c] = 32'sh7fffffff;
			else if (acc[c] < -(TW+2)'(64'sd2147483648)) tr[c] = 32'sh80000000;
			else tr[c] = 32'(acc[c]);
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			dout.m00 <= 16'(ms_s4[0]); dout.m01 <= 16'(ms_s4[1]); dout.m02 <= 16'(ms_s4[2]);
			dout.m10 <= 16'(ms_s4[3]); dout.m11 <= 16'(ms_s4[4]); dout.m12 <= 16'(ms_s4[5]);
			dout.m20 <= 16'(ms_s4[6]); dout.m21 <= 16'(ms_s4[7]); dout.m22 <= 16'(ms_s4[8]);
			dout.trans_x <= tr[0]; dout.trans_y <= tr[1]; dout.trans_z <= tr[2];
		end
	end
endmodule

// ===== hw/rtl/euler_to_view_matrix_unit.sv =====
// Top level: yaw-pitch-roll camera view matrix unit.
// Usage:
//  in_ch carries one word of three angles (signed fractions of a half turn)
//  and a Q16.16 camera position. out_ch carries one word per input: nine
//  Q2.14 rotation entries and a saturated Q16.16 translation.
//  Sine and cosine come from a chain of 30 CORDIC cells, one micro-rotation
//  each, shared by the three angles; five back-end stages follow.
//  Throughput is one word per cycle while out_ch is not stalled, set by the
//  cell chain advancing one step per clock.
//  The whole pipeline advances only when the output register is empty or
//  being taken, so a stalled receiver holds every word in place and in_ch
//  ready drops with it; nothing is lost or repeated.
//  Reset clears all valid flags; no result is pending after reset.
`timescale 1ns / 1ps
module euler_to_view_matrix_unit #(
	parameter int ANGLE_BITS = 16,
	parameter int ROT_FRAC_BITS = 14
) (
	input logic clk,
	input logic arst_n,
	etvm_if.sink in_ch,
	etvm_if.source out_ch
);
	import etvm_pkg::*;
	localparam int STEPS = CORDIC_STEPS;

	logic en;
	logic v [STEPS+1];
	lane_t d [STEPS+1];
	logic [15:0] ang [3];
	cs_t init [3];

	assign en = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = en;
	assign ang[0] = in_ch.data.pitch_angle;
	assign ang[1] = in_ch.data.yaw_angle;
	assign ang[2] = in_ch.data.roll_angle;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			logic [31:0] pw;
			logic signed [33:0] z;
			pw = 32'({{16{ang[k][15]}}, ang[k]} << (32 - ANGLE_BITS));
			z = 34'(signed'(pw));
			init[k].x = CORDIC_GAIN;
			init[k].y = '0;
			init[k].flip = (z > QUARTER) || (z < -QUARTER);
			init[k].z = init[k].flip ? (z[33] ? z + HALF : z - HALF) : z;
		end
		d[0].p = init[0];
		d[0].w = init[1];
		d[0].r = init[2];
		d[0].px = in_ch.data.pos_x;
		d[0].py = in_ch.data.pos_y;
		d[0].pz = in_ch.data.pos_z;
	end
	assign v[0] = in_ch.valid;

	for (genvar g = 0; g < STEPS; g++) begin : g_cell
		etvm_cell #(.STEP(g)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vin(v[g]), .din(d[g]), .vout(v[g+1]), .dout(d[g+1])
		);
	end

	res_t res;
	etvm_matrix #(.ROT_FRAC_BITS(ROT_FRAC_BITS)) u_mat (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vin(v[STEPS]), .din(d[STEPS]), .vout(out_ch.valid), .dout(res)
	);
	assign out_ch.data.m00 = res.m00;
	assign out_ch.data.m01 = res.m01;
	assign out_ch.data.m02 = res.m02;
	assign out_ch.data.m10 = res.m10;
	assign out_ch.data.m11 = res.m11;
	assign out_ch.data.m12 = res.m12;
	assign out_ch.data.m20 = res.m20;
	assign out_ch.data.m21 = res.m21;
	assign out_ch.data.m22 = res.m22;
	assign out_ch.data.trans_x = res.trans_x;
	assign out_ch.data.trans_y = res.trans_y;
	assign out_ch.data.trans_z = res.trans_z;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
		else $error("output word changed under stall");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |-> !in_ch.ready)
		else $error("input taken while pipeline stalled");
	a_adv: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> v[1])
		else $error("accepted word not in first cell");
endmodule
